/* hw/rtl/splitmix64_range_and_base_draw_core_macros.svh */
// Assertion macros shared by the checker of the splitmix64 draw core.
`ifndef SPLITMIX64_RANGE_AND_BASE_DRAW_CORE_MACROS_SVH
`define SPLITMIX64_RANGE_AND_BASE_DRAW_CORE_MACROS_SVH

// Same-cycle implication, sampled on i_clk and held off during reset.
`define SM64RB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sm64rb: assertion failed");

// Next-cycle implication, sampled on i_clk and held off during reset.
`define SM64RB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sm64rb: assertion failed");

`endif

/* hw/rtl/sm64rb_pkg.sv */
// Types, constants and the base lookup shared by the splitmix64 draw core.
package sm64rb_pkg;

    typedef enum logic [1:0] {
        MODE_SEED  = 2'd0,
        MODE_FRAC  = 2'd1,
        MODE_RANGE = 2'd2,
        MODE_BASE  = 2'd3
    } t_mode;

    localparam logic [1:0] CFG_INCLUDE_N   = 2'd0;
    localparam logic [1:0] CFG_LOWER_CASE  = 2'd1;
    localparam logic [1:0] CFG_RANDOM_CASE = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [63:0] GEN_RESET = 64'd1;
    localparam logic [63:0] GOLDEN    = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL1  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL2  = 64'h94D049BB133111EB;

    localparam logic [30:0] N5_TH_A = 31'd1717986919;
    localparam logic [30:0] N5_TH_T = 31'd1288490189;
    localparam logic [30:0] N5_TH_G = 31'd858993460;
    localparam logic [30:0] N5_TH_C = 31'd429496730;
    localparam logic [30:0] N4_TH_A = 31'd1610612736;
    localparam logic [30:0] N4_TH_T = 31'd1073741824;
    localparam logic [30:0] N4_TH_G = 31'd536870912;
    localparam logic [30:0] HALF_K  = 31'd1073741824;

    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_T      = 8'h54;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_C      = 8'h43;
    localparam logic [7:0] CHAR_N      = 8'h4E;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    typedef struct packed {
        t_mode       mode;
        logic [63:0] seed;
        logic [63:0] rmin;
        logic [63:0] rmax;
        logic [63:0] diff;
        logic        bad;
    } t_req;

    typedef struct packed {
        logic [30:0] fraction;
        logic [63:0] int_value;
        logic [7:0]  base_char;
        logic        range_error;
    } t_res;

    typedef struct packed {
        logic include_n;
        logic lower_case;
        logic random_case;
    } t_cfg;

    function automatic logic [7:0] pick_base(input logic [30:0] k, input logic include_n);
        logic [7:0] c;
        if (include_n) begin
            if (k >= N5_TH_A)      c = CHAR_A;
            else if (k >= N5_TH_T) c = CHAR_T;
            else if (k >= N5_TH_G) c = CHAR_G;
            else if (k >= N5_TH_C) c = CHAR_C;
            else                   c = CHAR_N;
        end else begin
            if (k >= N4_TH_A)      c = CHAR_A;
            else if (k >= N4_TH_T) c = CHAR_T;
            else if (k >= N4_TH_G) c = CHAR_G;
            else                   c = CHAR_C;
        end
        return c;
    endfunction

endpackage

/* hw/rtl/splitmix64_range_and_base_draw_core.sv */
// Requests pass the request queue; seed and empty range are answered from idle,
// fraction and base take two mixing multiplies, a random-case base a second draw,
// range adds RLO, RHI, RSUM, RFIX. A new request starts once the last is done; the
// single 32x32 multiplier does three partial products per mixing multiply, two for range.
// Reset is synchronous, active low: generator state 1, control and config 0, queue empty.
module splitmix64_range_and_base_draw_core
    import sm64rb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,  // seed_value, range_min, range_max
    input  logic [1:0]   s_axis_tuser,  // mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,  // fraction, int_value, base_char, zero pad
    output logic         m_axis_tuser,  // range_error
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic         i_cfg_data
);

    t_cfg r_cfg;
    t_req req;
    logic req_valid;
    logic req_pop;
    t_res res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INCLUDE_N:   r_cfg.include_n   <= i_cfg_data;
                CFG_LOWER_CASE:  r_cfg.lower_case  <= i_cfg_data;
                CFG_RANDOM_CASE: r_cfg.random_case <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sm64rb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_mode      (t_mode'(s_axis_tuser)),
        .i_seed      (s_axis_tdata[63:0]),
        .i_min       (s_axis_tdata[127:64]),
        .i_max       (s_axis_tdata[191:128]),
        .o_req       (req),
        .o_req_valid (req_valid),
        .i_req_pop   (req_pop)
    );

    sm64rb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req       (req),
        .i_req_valid (req_valid),
        .o_req_pop   (req_pop),
        .o_res       (res),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, res.base_char, res.int_value, res.fraction};
    assign m_axis_tuser = res.range_error;

endmodule

/* hw/rtl/sm64rb_front.sv */
// Front end: takes requests, classifies range requests and queues them.
module sm64rb_front
    import sm64rb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_mode       i_mode,
    input  logic [63:0] i_seed,
    input  logic [63:0] i_min,
    input  logic [63:0] i_max,
    output t_req        o_req,
    output logic        o_req_valid,
    input  logic        i_req_pop
);

    t_req                r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_cnt;
    logic                push;
    logic                pop;
    t_req                entry;

    // The difference is exact modulo 2^64 and only used when max is above min.
    always_comb begin
        entry.mode = i_mode;
        entry.seed = i_seed;
        entry.rmin = i_min;
        entry.rmax = i_max;
        entry.diff = i_max - i_min;
        entry.bad  = !($signed(i_min) < $signed(i_max));
    end

    assign o_ready     = (r_cnt != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign push        = i_valid && o_ready;
    assign pop         = i_req_pop && (r_cnt != '0);
    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            if (push && !pop)      r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= entry;
    end

endmodule

/* hw/rtl/sm64rb_back.sv */
// Back end: generator state, shared 32x32 multiplier and result register.
module sm64rb_back
    import sm64rb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  t_req i_req,
    input  logic i_req_valid,
    output logic o_req_pop,
    output t_res o_res,
    output logic o_res_valid,
    input  logic i_res_ready
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_USE, S_RLO, S_RHI, S_RSUM, S_RFIX
    } t_state;

    t_state      r_state, n_state;
    logic [63:0] r_gen, n_gen;
    logic [63:0] r_z, n_z;
    logic [63:0] r_acc, n_acc;
    logic        r_round, n_round;
    logic [1:0]  r_part, n_part;
    logic        r_second, n_second;
    logic [7:0]  r_char, n_char;
    logic [30:0] r_k, n_k;
    logic [63:0] r_q, n_q;
    logic [63:0] r_res, n_res;
    logic        r_rnz, n_rnz;
    t_mode       r_mode, n_mode;
    logic [63:0] r_min, n_min;
    logic [63:0] r_max, n_max;
    logic [63:0] r_diff, n_diff;
    t_res        r_out, n_out;
    logic        r_out_valid, n_out_valid;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [63:0] mix_c;
    logic [63:0] mac_sum;
    logic [63:0] gen_next;
    logic [63:0] z_start;
    logic [63:0] w;
    logic [30:0] k;
    logic [7:0]  base;
    logic [63:0] fix;
    logic        out_free;

    assign mix_c    = r_round ? MIX_MUL2 : MIX_MUL1;
    assign gen_next = r_gen + GOLDEN;
    assign z_start  = gen_next ^ (gen_next >> 30);
    assign w        = r_acc ^ (r_acc >> 31);
    assign k        = w[63:33];
    assign base     = pick_base(k, i_cfg.include_n);
    assign fix      = r_res + {63'd0, r_rnz & r_res[63]};
    assign out_free = !r_out_valid || i_res_ready;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MUL: begin
                mul_a = (r_part == 2'd2) ? r_z[63:32] : r_z[31:0];
                mul_b = (r_part == 2'd1) ? mix_c[63:32] : mix_c[31:0];
            end
            S_RLO: begin
                mul_a = r_diff[31:0];
                mul_b = {1'b0, r_k};
            end
            S_RHI: begin
                mul_a = r_diff[63:32];
                mul_b = {1'b0, r_k};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign mac_sum = (r_part == 2'd0) ? prod : r_acc + {prod[31:0], 32'd0};

    always_comb begin
        n_state     = r_state;
        n_gen       = r_gen;
        n_z         = r_z;
        n_acc       = r_acc;
        n_round     = r_round;
        n_part      = r_part;
        n_second    = r_second;
        n_char      = r_char;
        n_k         = r_k;
        n_q         = r_q;
        n_res       = r_res;
        n_rnz       = r_rnz;
        n_mode      = r_mode;
        n_min       = r_min;
        n_max       = r_max;
        n_diff      = r_diff;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_res_ready;
        o_req_pop   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid && out_free) begin
                    o_req_pop = 1'b1;
                    n_mode    = i_req.mode;
                    n_min     = i_req.rmin;
                    n_max     = i_req.rmax;
                    n_diff    = i_req.diff;
                    n_second  = 1'b0;
                    if (i_req.mode == MODE_SEED) begin
                        n_gen       = i_req.seed;
                        n_out       = '0;
                        n_out_valid = 1'b1;
                    end else if (i_req.mode == MODE_RANGE && i_req.bad) begin
                        n_out             = '0;
                        n_out.range_error = 1'b1;
                        n_out_valid       = 1'b1;
                    end else begin
                        n_gen   = gen_next;
                        n_z     = z_start;
                        n_round = 1'b0;
                        n_part  = 2'd0;
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_acc = mac_sum;
                if (r_part == 2'd2) begin
                    n_part = 2'd0;
                    if (!r_round) begin
                        n_round = 1'b1;
                        n_z     = mac_sum ^ (mac_sum >> 27);
                    end else begin
                        n_state = S_USE;
                    end
                end else begin
                    n_part = r_part + 2'd1;
                end
            end
            S_USE: begin
                n_out   = '0;
                n_state = S_IDLE;
                case (r_mode)
                    MODE_FRAC: begin
                        n_out.fraction = k;
                        n_out_valid    = 1'b1;
                    end
                    MODE_RANGE: begin
                        n_k     = k;
                        n_state = S_RLO;
                    end
                    default: begin
                        if (r_second) begin
                            n_out.base_char = (k > HALF_K) ? r_char + CASE_OFFSET : r_char;
                            n_out_valid     = 1'b1;
                        end else if (i_cfg.lower_case) begin
                            n_out.base_char = base + CASE_OFFSET;
                            n_out_valid     = 1'b1;
                        end else if (i_cfg.random_case) begin
                            n_char   = base;
                            n_second = 1'b1;
                            n_gen    = gen_next;
                            n_z      = z_start;
                            n_round  = 1'b0;
                            n_part   = 2'd0;
                            n_state  = S_MUL;
                        end else begin
                            n_out.base_char = base;
                            n_out_valid     = 1'b1;
                        end
                    end
                endcase
            end
            S_RLO: begin
                n_acc   = prod;
                n_state = S_RHI;
            end
            S_RHI: begin
                n_q     = {prod[62:0], 1'b0} + {31'd0, r_acc[63:31]};
                n_rnz   = |r_acc[30:0];
                n_state = S_RSUM;
            end
            S_RSUM: begin
                n_res   = r_min + r_q;
                n_state = S_RFIX;
            end
            S_RFIX: begin
                n_out = '0;
                if ($signed(fix) < $signed(r_max)) n_out.int_value = fix;
                else                               n_out.int_value = r_max - 64'd1;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gen       <= GEN_RESET;
            r_out_valid <= 1'b0;
            r_round     <= 1'b0;
            r_part      <= 2'd0;
            r_second    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gen       <= n_gen;
            r_out_valid <= n_out_valid;
            r_round     <= n_round;
            r_part      <= n_part;
            r_second    <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z    <= n_z;
        r_acc  <= n_acc;
        r_char <= n_char;
        r_k    <= n_k;
        r_q    <= n_q;
        r_res  <= n_res;
        r_rnz  <= n_rnz;
        r_mode <= n_mode;
        r_min  <= n_min;
        r_max  <= n_max;
        r_diff <= n_diff;
        r_out  <= n_out;
    end

    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;

endmodule

/* hw/rtl/sm64rb_checker.sv */
// Port-level checker for the splitmix64 draw core, bound to the top level.
`include "splitmix64_range_and_base_draw_core_macros.svh"

module sm64rb_checker
    import sm64rb_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    logic [7:0] chr;
    logic       out_stall;
    logic       rest_clear;
    logic       chr_legal;

    // A letter is legal in either case, so the case bit is cleared before the lookup.
    assign chr        = m_axis_tdata[102:95];
    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign rest_clear = (m_axis_tdata[103:31] == '0) && !m_axis_tuser;
    assign chr_legal  = (chr & ~CASE_OFFSET) inside {CHAR_A, CHAR_T, CHAR_G, CHAR_C, CHAR_N};

    `SM64RB_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable({m_axis_tuser, m_axis_tdata}))
    `SM64RB_ASSERT_NOW(a_err_clean, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
    `SM64RB_ASSERT_NOW(a_frac_only, m_axis_tvalid && (m_axis_tdata[30:0] != '0), rest_clear)
    `SM64RB_ASSERT_NOW(a_char_legal, m_axis_tvalid && (chr != '0), chr_legal)

endmodule

bind splitmix64_range_and_base_draw_core sm64rb_checker u_checker (.*);
